FILE: rtl/core/emx_pkg.sv
// shared constants and types of the multi-tap echo mixer
// no dependencies; used by every module under rtl/core except emx_hist_ram
package emx_pkg;

  localparam int NUM_TAPS      = 4;
  localparam int TAP_REGS      = 4;
  localparam int QUEUE_BLOCKS  = 256;
  localparam int BLOCK_SAMPLES = 128;
  localparam int STORE_DEPTH   = QUEUE_BLOCKS * BLOCK_SAMPLES;

  localparam int SAMPLE_W = 16;
  localparam int DELAY_W  = 9;
  localparam int SHIFT_W  = 4;
  localparam int CFG_W    = DELAY_W;
  localparam int INDEX_W  = 4;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int SEEN_W = $clog2(STORE_DEPTH + 1);
  localparam int BS_W   = $clog2(BLOCK_SAMPLES + 1);
  localparam int LAG_W  = DELAY_W + BS_W;
  localparam int CMP_W  = (LAG_W > SEEN_W) ? LAG_W : SEEN_W;
  localparam int TAP_W  = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam int TSEL_W = $clog2(TAP_REGS);

  // register indexes on the configuration port
  localparam logic [INDEX_W-1:0] REG_DELAY_BASE = INDEX_W'(0);
  localparam logic [INDEX_W-1:0] REG_SHIFT_BASE = INDEX_W'(TAP_REGS);
  localparam logic [INDEX_W-1:0] REG_END        = INDEX_W'(2 * TAP_REGS);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef logic [TAP_REGS-1:0][DELAY_W-1:0] delay_arr_t;
  typedef logic [TAP_REGS-1:0][SHIFT_W-1:0] shift_arr_t;

  // one tap step handed from the sequencer to the mixer
  typedef struct packed {
    logic                       valid;
    logic                       en;
    logic                       first;
    logic                       last;
    logic [SHIFT_W-1:0]         shift;
    logic signed [SAMPLE_W-1:0] sample;
  } tap_req_t;

endpackage

FILE: rtl/core/emx_hist_ram.sv
// generic simple dual-port ram, one write and one registered read port
// read-first when both ports hit the same entry; no dependencies
module emx_hist_ram #(
  parameter int DEPTH  = 32768,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/emx_tap_seq.sv
// tap sequencer: one history read per tap per sample, the sample write issued with the last read
// depends on emx_pkg
module emx_tap_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [emx_pkg::SAMPLE_W-1:0] sample,
  input  emx_pkg::delay_arr_t             delays,
  input  emx_pkg::shift_arr_t             shifts,
  output logic                            can_take,
  output logic [emx_pkg::ADDR_W-1:0]      raddr,
  output logic                            we,
  output logic [emx_pkg::ADDR_W-1:0]      waddr,
  output logic [emx_pkg::SAMPLE_W-1:0]    wdata,
  output emx_pkg::tap_req_t               req
);

  localparam logic [emx_pkg::TAP_W-1:0] LAST_TAP = emx_pkg::TAP_W'(emx_pkg::NUM_TAPS - 1);

  logic                              busy;
  logic [emx_pkg::TAP_W-1:0]         tap;
  logic signed [emx_pkg::SAMPLE_W-1:0] x;
  logic [emx_pkg::ADDR_W-1:0]        wp;
  logic [emx_pkg::SEEN_W-1:0]        seen;

  logic                              at_last;
  logic [emx_pkg::TSEL_W-1:0]        tsel;
  logic [emx_pkg::DELAY_W-1:0]       d;
  logic [emx_pkg::CMP_W-1:0]         lag;
  logic                              d_ok;
  logic                              hist_ok;
  logic [emx_pkg::SEEN_W:0]          wp_ext;
  logic [emx_pkg::SEEN_W:0]          lag_ext;
  logic [emx_pkg::SEEN_W:0]          pos;

  assign at_last  = busy && (tap == LAST_TAP);
  assign can_take = !busy || (tap == LAST_TAP);

  assign tsel = emx_pkg::TSEL_W'(tap);
  assign d    = delays[tsel];
  assign lag  = emx_pkg::CMP_W'(d) * emx_pkg::CMP_W'(emx_pkg::BLOCK_SAMPLES);
  assign d_ok = (d != '0) && (emx_pkg::CMP_W'(d) <= emx_pkg::CMP_W'(emx_pkg::QUEUE_BLOCKS));
  assign hist_ok = emx_pkg::CMP_W'(seen) >= lag;

  // lag never exceeds the store depth once d_ok holds
  assign wp_ext  = (emx_pkg::SEEN_W + 1)'(wp);
  assign lag_ext = (emx_pkg::SEEN_W + 1)'(lag);
  assign pos = (wp_ext >= lag_ext) ? (wp_ext - lag_ext)
             : (wp_ext + (emx_pkg::SEEN_W + 1)'(emx_pkg::STORE_DEPTH) - lag_ext);
  assign raddr = pos[emx_pkg::ADDR_W-1:0];

  // write on the last read so a full-depth tap still sees the old entry
  assign we    = at_last;
  assign waddr = wp;
  assign wdata = x;

  always_comb begin
    req.valid  = busy;
    req.en     = busy && d_ok && hist_ok;
    req.first  = (tap == '0);
    req.last   = (tap == LAST_TAP);
    req.shift  = shifts[tsel];
    req.sample = x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      tap  <= '0;
      wp   <= '0;
      seen <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        tap  <= '0;
      end else if (at_last) begin
        busy <= 1'b0;
        tap  <= '0;
      end else if (busy) begin
        tap <= tap + 1'b1;
      end
      if (at_last) begin
        wp <= (emx_pkg::SEEN_W'(wp) == emx_pkg::SEEN_W'(emx_pkg::STORE_DEPTH - 1))
            ? '0 : wp + 1'b1;
        if (seen < emx_pkg::SEEN_W'(emx_pkg::STORE_DEPTH)) begin
          seen <= seen + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= sample;
    end
  end

endmodule

FILE: rtl/core/emx_mix.sv
// echo mixer: shifts each read echo, adds it and saturates after every tap
// depends on emx_pkg
module emx_mix (
  input  logic                                clk,
  input  logic                                rst,
  input  emx_pkg::tap_req_t                   req,
  input  logic [emx_pkg::SAMPLE_W-1:0]        rdata,
  output logic                                push,
  output logic signed [emx_pkg::SAMPLE_W-1:0] result
);

  emx_pkg::tap_req_t                   req_q;
  logic signed [emx_pkg::SAMPLE_W-1:0] acc;
  logic signed [emx_pkg::SAMPLE_W-1:0] acc_next;
  logic signed [emx_pkg::SAMPLE_W-1:0] cur;
  logic signed [emx_pkg::SAMPLE_W-1:0] echo;
  logic signed [emx_pkg::SAMPLE_W:0]   sum;

  always_comb begin
    cur  = req_q.first ? req_q.sample : acc;
    echo = $signed(rdata) >>> req_q.shift;
    sum  = {cur[emx_pkg::SAMPLE_W-1], cur} + {echo[emx_pkg::SAMPLE_W-1], echo};
    if (!req_q.en) begin
      acc_next = cur;
    end else if (sum > (emx_pkg::SAMPLE_W + 1)'(emx_pkg::SAMPLE_MAX)) begin
      acc_next = emx_pkg::SAMPLE_MAX;
    end else if (sum < (emx_pkg::SAMPLE_W + 1)'(emx_pkg::SAMPLE_MIN)) begin
      acc_next = emx_pkg::SAMPLE_MIN;
    end else begin
      acc_next = sum[emx_pkg::SAMPLE_W-1:0];
    end
  end

  assign push   = req_q.valid && req_q.last;
  assign result = acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q <= '0;
    end else begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (req_q.valid) begin
      acc <= acc_next;
    end
  end

endmodule

FILE: rtl/core/emx_out_buf.sv
// two-entry result queue in front of the output channel
// depends on emx_pkg
module emx_out_buf (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic signed [emx_pkg::SAMPLE_W-1:0] din,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [emx_pkg::SAMPLE_W-1:0] dout
);

  logic signed [emx_pkg::SAMPLE_W-1:0] slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign dout      = slot[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= din;
    end
  end

endmodule

FILE: rtl/core/multi_tap_echo_mixer_unit.sv
// top level of the multi-tap echo mixer: config registers, credit count, datapath
// depends on emx_pkg, emx_hist_ram, emx_tap_seq, emx_mix, emx_out_buf
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------
//   input    | in_valid / in_ready  | sample_in  (s16)
//   output   | out_valid / out_ready| sample_out (s16)
//   config   | cfg_we               | cfg_index (4b), cfg_data (9b)
//
// the single history read port serves one tap per cycle, so a new sample is taken
// no earlier than the read of the last tap of the sample before
// rst is synchronous; the history memory is not cleared, a tap never uses an
// entry that was not written since reset
// two transactions in flight or queued hold in_ready low until a result leaves
module multi_tap_echo_mixer_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [emx_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [emx_pkg::SAMPLE_W-1:0] sample_out,
  input  logic                                cfg_we,
  input  logic [emx_pkg::INDEX_W-1:0]         cfg_index,
  input  logic [emx_pkg::CFG_W-1:0]           cfg_data
);

  // tap configuration
  emx_pkg::delay_arr_t delays;
  emx_pkg::shift_arr_t shifts;

  // transactions accepted whose results have not left yet
  logic [1:0] credits;

  logic                             start;
  logic                             out_take;
  logic                             can_take;
  logic [emx_pkg::ADDR_W-1:0]       raddr;
  logic                             we;
  logic [emx_pkg::ADDR_W-1:0]       waddr;
  logic [emx_pkg::SAMPLE_W-1:0]     wdata;
  logic [emx_pkg::SAMPLE_W-1:0]     rdata;
  emx_pkg::tap_req_t                req;
  logic                             mix_push;
  logic signed [emx_pkg::SAMPLE_W-1:0] mix_result;

  // the queue has room for every transaction that holds a credit
  assign in_ready = can_take && (credits != 2'd2);
  assign start    = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= 2'd0;
    end else if (start && !out_take) begin
      credits <= credits + 2'd1;
    end else if (out_take && !start) begin
      credits <= credits - 2'd1;
    end
  end

  // config writes; indexes past the shift registers are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      delays <= '0;
      shifts <= '0;
    end else if (cfg_we) begin
      if (cfg_index < emx_pkg::REG_SHIFT_BASE) begin
        delays[cfg_index[emx_pkg::TSEL_W-1:0]] <= cfg_data;
      end else if (cfg_index < emx_pkg::REG_END) begin
        shifts[cfg_index[emx_pkg::TSEL_W-1:0]] <= cfg_data[emx_pkg::SHIFT_W-1:0];
      end
    end
  end

  // sequencer walks the taps and owns write position and fill count
  emx_tap_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .sample   (sample_in),
    .delays   (delays),
    .shifts   (shifts),
    .can_take (can_take),
    .raddr    (raddr),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .req      (req)
  );

  // sample history, one read and one write per cycle
  emx_hist_ram #(
    .DEPTH  (emx_pkg::STORE_DEPTH),
    .WIDTH  (emx_pkg::SAMPLE_W),
    .ADDR_W (emx_pkg::ADDR_W)
  ) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // running sum, one tap per cycle behind the read
  emx_mix u_mix (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rdata  (rdata),
    .push   (mix_push),
    .result (mix_result)
  );

  emx_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (mix_push),
    .din       (mix_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (sample_out)
  );

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits != 2'd3)
    else $error("credit count overflow");

  a_out_has_credit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> credits != 2'd0)
    else $error("result without an accepted transaction");

  a_push_has_credit: assert property (@(posedge clk) disable iff (rst)
    mix_push |-> credits != 2'd0)
    else $error("mixer finished a transaction that was never accepted");

  a_write_after_start: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(emx_pkg::NUM_TAPS) we)
    else $error("history write missing after accepted transaction");
`endif

endmodule

FILE: dv/tb_multi_tap_echo_mixer_unit.sv
// self-checking bench for multi_tap_echo_mixer_unit: directed table, random traffic
// keeps its own echo mixer model with a shadow copy of the tap registers
// depends on emx_pkg and the sources under rtl/core
module tb_multi_tap_echo_mixer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import emx_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 5;
  localparam int MAX_GAP       = 18;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SEGMENT_LEN   = 100;
  localparam int WARM_SEGMENTS = 9;
  localparam int FLOOD_SEGMENT = 3;
  localparam int FLOOD_ITEMS   = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4 * NUM_TAPS + 8;

  // ---------------------------------------------------------------------------
  // dut signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       cfg_we    = 1'b0;
  logic [INDEX_W-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data  = '0;

  multi_tap_echo_mixer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // echo model state: shadow registers, sample history, fill level
  // ---------------------------------------------------------------------------
  logic [DELAY_W-1:0]         tap_delay_sh [TAP_REGS];
  logic [SHIFT_W-1:0]         tap_shift_sh [TAP_REGS];
  logic signed [SAMPLE_W-1:0] echo_history [STORE_DEPTH];
  int unsigned                hist_wr_pos = 0;
  int unsigned                hist_fill   = 0;

  // mixed samples still owed by the dut, oldest first
  logic signed [SAMPLE_W-1:0] expected_mix_q [$];

  int fail_count     = 0;
  int tx_gap_max     = 0;
  int rx_gap_max     = 0;
  int rx_hold_cycles = 0;
  int cycle_count    = 0;

  // directed stimulus: either a register write or a sample with its mix typed in
  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [INDEX_W-1:0]         index;
    logic [CFG_W-1:0]           data;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       pinned;
    logic signed [SAMPLE_W-1:0] mix;
  } stim_row_t;

  localparam int DIR_ROWS = 23;
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    // all taps off after reset: output equals input, full-scale values included
    '{ROW_SAMPLE, '0, '0, 16'sd0,      1'b1, 16'sd0},
    '{ROW_SAMPLE, '0, '0, SAMPLE_MAX,  1'b1, SAMPLE_MAX},
    '{ROW_SAMPLE, '0, '0, SAMPLE_MIN,  1'b1, SAMPLE_MIN},
    '{ROW_SAMPLE, '0, '0, -16'sd1,     1'b1, -16'sd1},
    '{ROW_SAMPLE, '0, '0, 16'sd1,      1'b1, 16'sd1},
    '{ROW_SAMPLE, '0, '0, 16'sh5555,   1'b1, 16'sh5555},
    '{ROW_SAMPLE, '0, '0, 16'shaaaa,   1'b1, 16'shaaaa},
    // writes past the last register must not touch any tap
    '{ROW_WRITE, REG_END, 9'h1ff, '0, 1'b0, '0},
    '{ROW_WRITE, REG_END + INDEX_W'(7), 9'h155, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 16'sd12345,  1'b1, 16'sd12345},
    // tap 0 one block back but history too short, tap 1 beyond the queue,
    // tap 2 at full depth (also short of history), tap 3 at the largest code
    '{ROW_WRITE, REG_DELAY_BASE,               9'd1,   '0, 1'b0, '0},
    '{ROW_WRITE, REG_DELAY_BASE + INDEX_W'(1), 9'(QUEUE_BLOCKS + 1), '0, 1'b0, '0},
    '{ROW_WRITE, REG_DELAY_BASE + INDEX_W'(2), 9'(QUEUE_BLOCKS),     '0, 1'b0, '0},
    '{ROW_WRITE, REG_DELAY_BASE + INDEX_W'(3), 9'h1ff, '0, 1'b0, '0},
    // shift extremes; upper data bits beyond the shift field are dropped
    '{ROW_WRITE, REG_SHIFT_BASE,               9'd0,   '0, 1'b0, '0},
    '{ROW_WRITE, REG_SHIFT_BASE + INDEX_W'(1), 9'd15,  '0, 1'b0, '0},
    '{ROW_WRITE, REG_SHIFT_BASE + INDEX_W'(2), 9'h1f0, '0, 1'b0, '0},
    '{ROW_WRITE, REG_SHIFT_BASE + INDEX_W'(3), 9'h00f, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, SAMPLE_MIN,  1'b1, SAMPLE_MIN},
    '{ROW_SAMPLE, '0, '0, SAMPLE_MAX,  1'b1, SAMPLE_MAX},
    '{ROW_SAMPLE, '0, '0, -16'sd2,     1'b1, -16'sd2},
    '{ROW_SAMPLE, '0, '0, 16'sd2,      1'b1, 16'sd2},
    '{ROW_SAMPLE, '0, '0, 16'sh0100,   1'b1, 16'sh0100}
  };

  // ---------------------------------------------------------------------------
  // model: mix one sample with the enabled echoes, then record it in history
  // ---------------------------------------------------------------------------
  function automatic logic signed [SAMPLE_W-1:0] echo_mix_predict(
      input logic signed [SAMPLE_W-1:0] x);
    int          acc;
    int unsigned lag;
    int unsigned pos;
    acc = x;
    for (int t = 0; t < NUM_TAPS; t++) begin
      // zero or out-of-range delay disables the tap
      if (tap_delay_sh[t] == 0 || tap_delay_sh[t] > QUEUE_BLOCKS) continue;
      lag = tap_delay_sh[t] * BLOCK_SAMPLES;
      // not enough samples seen yet for this echo
      if (hist_fill < lag) continue;
      pos = (hist_wr_pos >= lag) ? hist_wr_pos - lag : hist_wr_pos + STORE_DEPTH - lag;
      acc += int'(echo_history[pos]) >>> tap_shift_sh[t];
      // saturate after every tap, not just at the end
      if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
      else if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
    end
    // history is read before the new sample goes in
    echo_history[hist_wr_pos] = x;
    hist_wr_pos = (hist_wr_pos + 1) % STORE_DEPTH;
    if (hist_fill < STORE_DEPTH) hist_fill++;
    return SAMPLE_W'(acc);
  endfunction

  // ---------------------------------------------------------------------------
  // random field pickers
  // ---------------------------------------------------------------------------
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // mostly delays the current history can serve (or just miss), plus the odd cases
  function automatic logic [DELAY_W-1:0] pick_delay();
    int reach;
    reach = hist_fill / BLOCK_SAMPLES + 1;
    if (reach > QUEUE_BLOCKS) reach = QUEUE_BLOCKS;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return DELAY_W'(QUEUE_BLOCKS);
      2: return DELAY_W'($urandom_range(QUEUE_BLOCKS + 1, 2 ** DELAY_W - 1));
      default: return DELAY_W'($urandom_range(1, reach));
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return SHIFT_W'($urandom_range(0, 2 ** SHIFT_W - 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one register write at the next edge; cfg_we is left high for back-to-back writes
  task automatic cfg_write(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx < REG_SHIFT_BASE) tap_delay_sh[idx - REG_DELAY_BASE] = data;
    else if (idx < REG_END) tap_shift_sh[idx - REG_SHIFT_BASE] = data[SHIFT_W-1:0];
  endtask

  // stop offering and wait until every owed mix has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    do @(negedge clk); while (expected_mix_q.size() != 0);
    @(posedge clk);
  endtask

  // offer one sample after a random gap; valid stays up for a back-to-back follower
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic pinned,
                             input logic signed [SAMPLE_W-1:0] pinned_mix);
    int                         gap;
    logic signed [SAMPLE_W-1:0] mix;
    gap = $urandom_range(0, tx_gap_max);
    if (cfg_we) cfg_we <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (!in_ready);
    // transaction accepted at this edge
    mix = echo_mix_predict(x);
    expected_mix_q.push_back(pinned ? pinned_mix : mix);
  endtask

  // new random setting of all eight registers, sometimes a stray write past the end
  task automatic set_taps();
    drain_results();
    for (int t = 0; t < TAP_REGS; t++) begin
      cfg_write(REG_DELAY_BASE + INDEX_W'(t), CFG_W'(pick_delay()));
      cfg_write(REG_SHIFT_BASE + INDEX_W'(t),
                {(CFG_W - SHIFT_W)'($urandom_range(0, 2 ** (CFG_W - SHIFT_W) - 1)),
                 pick_shift()});
    end
    if ($urandom_range(0, 2) == 0)
      cfg_write(REG_END + INDEX_W'($urandom_range(0, 7)), CFG_W'($urandom()));
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls, plus one long hold-off when requested
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = $urandom_range(0, rx_gap_max);
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare every accepted output transaction with the oldest owed mix
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_mix_q.size() == 0) begin
        fail_count++;
        $display("%0t: sample_out expected none, actual %0d", $time, sample_out);
      end else begin
        want = expected_mix_q.pop_front();
        if (sample_out !== want) begin
          fail_count++;
          $display("%0t: sample_out expected %0d, actual %0d", $time, want, sample_out);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int seg;
    for (int t = 0; t < TAP_REGS; t++) begin
      tap_delay_sh[t] = '0;
      tap_shift_sh[t] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, both sides idling at random
    tx_gap_max = MAX_GAP;
    rx_gap_max = MAX_GAP;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].kind == ROW_WRITE) begin
        drain_results();
        cfg_write(DIR_TABLE[r].index, DIR_TABLE[r].data);
      end else begin
        send_sample(DIR_TABLE[r].sample, DIR_TABLE[r].pinned, DIR_TABLE[r].mix);
      end
    end

    // history builds up; delays follow what it can serve so echoes stay live
    for (seg = 0; seg < WARM_SEGMENTS; seg++) begin
      set_taps();
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
      rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
      if (seg == FLOOD_SEGMENT) begin
        // sink holds off for a long stretch while samples keep coming, so the
        // result queue fills and in_ready has to drop
        tx_gap_max     = 0;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (FLOOD_ITEMS) send_sample(pick_sample(), 1'b0, '0);
        tx_gap_max = MAX_GAP;
      end
      repeat (SEGMENT_LEN) send_sample(pick_sample(), 1'b0, '0);
    end

    // let stray results show up before the verdict
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
